@@ design/emulated_servo_position_integrator_macros.svh @@
// Assertion macros used by the checker file of the servo position integrator
`ifndef EMULATED_SERVO_POSITION_INTEGRATOR_MACROS_SVH
`define EMULATED_SERVO_POSITION_INTEGRATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define ESP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ESP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/esp_pkg.sv @@
// Types, constants and helper functions of the servo position integrator
`default_nettype none
package esp_pkg;

   localparam logic [15:0] NOMINAL_TICK_US = 16'd5000;
   localparam logic [15:0] MAX_TICK_US     = 16'd50000;

   // divider widths: numerator, divisor, iteration counter
   localparam int unsigned NUM_W     = 37;
   localparam int unsigned DEN_W     = 19;
   localparam int unsigned DIV_CNT_W = 6;

   // reciprocals of 125 for the divisions by 1000, operand shifted down by 3 first
   localparam logic [33:0] RECIP_STEP = 34'd8796093023;  // ceil(2^40 / 125)
   localparam logic [29:0] RECIP_POS  = 30'd549755814;   // ceil(2^36 / 125)

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_SWITCH  = 2'd1;
   localparam logic [1:0] KIND_ENCODER = 2'd2;

   localparam logic [3:0] CSR_MAX_SPEED        = 4'd0;
   localparam logic [3:0] CSR_CURRENT_GAIN     = 4'd1;
   localparam logic [3:0] CSR_EFFORT_LIMIT     = 4'd2;
   localparam logic [3:0] CSR_POS_CLAMP        = 4'd3;
   localparam logic [3:0] CSR_SWITCH_THRESHOLD = 4'd4;
   localparam logic [3:0] CSR_MODE_BITS        = 4'd5;
   localparam logic [3:0] CSR_ENCODER_OFFSET   = 4'd6;
   localparam logic [3:0] CSR_ENCODER_SCALE    = 4'd7;

   localparam int unsigned MODE_SW_EN     = 0;
   localparam int unsigned MODE_BELOW     = 1;
   localparam int unsigned MODE_ACT_HIGH  = 2;
   localparam int unsigned MODE_ENC_EN    = 3;

   typedef struct packed {
      logic        [19:0] max_speed;
      logic        [23:0] current_gain;
      logic        [14:0] effort_limit;
      logic        [30:0] pos_clamp;
      logic signed [31:0] switch_threshold;
      logic        [3:0]  mode_bits;
      logic signed [31:0] encoder_offset;
      logic signed [31:0] encoder_scale;
   } cfg_type;

   typedef struct packed {
      logic               is_cmd;
      logic               cmd_ok;
      logic        [15:0] dt;
      logic signed [31:0] target;
   } item_type;

   typedef struct packed {
      logic        [1:0]  frame_kind;
      logic signed [15:0] position_tenth_deg;
      logic signed [15:0] velocity_tenth_rpm;
      logic signed [15:0] current_centiamp;
      logic               switch_pressed;
      logic signed [23:0] encoder_raw;
      logic               last;
   } rsp_type;

   function automatic logic signed [31:0] limit_pos(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
      logic signed [31:0] hi;
      hi = signed'({1'b0, lim});
      if (lim == 31'd0) return v;
      if (v > hi) return hi;
      if (v < -hi) return -hi;
      return v;
   endfunction

   function automatic logic signed [15:0] sat16(input logic neg,
                                               input logic [NUM_W-1:0] mag);
      if (neg) begin
         if (mag > NUM_W'(32768)) return 16'sh8000;
         return -signed'(mag[15:0]);
      end
      if (mag > NUM_W'(32767)) return 16'sh7FFF;
      return signed'(mag[15:0]);
   endfunction

endpackage
`default_nettype wire

@@ design/esp_front.sv @@
// Front end: accepts and classifies items into a two-entry queue
`default_nettype none
module esp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [15:0]        req_elapsed_us,
   input  logic               req_is_extended,
   input  logic [3:0]         req_frame_length,
   input  logic signed [31:0] req_target_raw,
   output logic               q_valid,
   output esp_pkg::item_type  q_item,
   input  logic               q_pop
);
   import esp_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   item_w;
   logic       push;

   always_comb begin
      item_w.is_cmd = req_type;
      item_w.cmd_ok = req_is_extended && (req_frame_length >= 4'd4);
      item_w.target = req_target_raw;
      // zero means nominal period, otherwise cap at the maximum
      if (req_elapsed_us == 16'd0)
         item_w.dt = NOMINAL_TICK_US;
      else if ((MAX_TICK_US != 16'd0) && (req_elapsed_us > MAX_TICK_US))
         item_w.dt = MAX_TICK_US;
      else
         item_w.dt = req_elapsed_us;
      if (item_w.dt == 16'd0) item_w.dt = 16'd1;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= item_w;
   end

endmodule
`default_nettype wire

@@ design/esp_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module esp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [esp_pkg::NUM_W-1:0]      num,
   input  logic [esp_pkg::DEN_W-1:0]      den,
   output logic                           done,
   output logic [esp_pkg::NUM_W-1:0]      quot
);
   import esp_pkg::*;

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       shifted;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
      quo_in  = {quo_ff[NUM_W-2:0], fits};
      cnt_in  = cnt_ff - DIV_CNT_W'(1);
      done_in = (cnt_ff == DIV_CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= DIV_CNT_W'(NUM_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule
`default_nettype wire

@@ design/esp_back.sv @@
// Back end: tick sequencer, servo state and result register
`default_nettype none
module esp_back (
   input  logic              clock,
   input  logic              reset,
   input  esp_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  esp_pkg::item_type q_item,
   output logic              q_pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output esp_pkg::rsp_type  rsp
);
   import esp_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_MMUL  = 16'h0002,
      S_MLO   = 16'h0004,
      S_MHI   = 16'h0008,
      S_STEP  = 16'h0010,
      S_VDIV  = 16'h0020,
      S_VWAIT = 16'h0040,
      S_PMUL  = 16'h0080,
      S_CMUL  = 16'h0100,
      S_CRND  = 16'h0200,
      S_ELO   = 16'h0400,
      S_EHI   = 16'h0800,
      S_ERND  = 16'h1000,
      S_OSTAT = 16'h2000,
      S_OSW   = 16'h4000,
      S_OENC  = 16'h8000
   } state_type;

   state_type          state_ff, state_in;
   logic signed [31:0] position_ff, target_ff;
   logic [15:0]        dt_ff;
   logic [35:0]        mprod_ff;
   logic [49:0]        macc_ff;
   logic [32:0]        step_cap_ff;
   logic [32:0]        err_mag_ff, step_mag_ff;
   logic               err_neg_ff, step_neg_ff, pinned_ff;
   logic signed [15:0] vel_ff, pos_ff, cur_ff;
   logic [56:0]        cprod_ff;
   logic [32:0]        emag_ff;
   logic [31:0]        smag_ff;
   logic               eneg_ff;
   logic [64:0]        eacc_ff;
   logic signed [23:0] enc_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // divider port
   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_num, div_quot;
   logic [DEN_W-1:0]   div_den;

   // reciprocal datapath for the divisions by 1000
   logic [32:0]        mq_x;
   logic [49:0]        mq_hi;
   logic [66:0]        mq_sum;
   logic [31:0]        pq_y;
   logic [58:0]        pq_prod;

   // step datapath
   logic signed [32:0] err_w, ms_s, step_w;
   logic               err_neg, big;
   logic [32:0]        err_mag;
   logic signed [33:0] nsum, lim34;
   logic signed [31:0] newpos;
   logic [31:0]        newpos_mag, pos_mag;
   logic               pinned_w;

   // rounding and encoder datapath
   logic [57:0]        csum;
   logic [33:0]        cq;
   logic [14:0]        cmag;
   logic signed [32:0] esum33;
   logic [64:0]        esum;
   logic [48:0]        eq;
   logic               trig, pressed, out_free, sw_en, enc_en;

   esp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // velocity: round(step * 500 / (3 * dt)) as (1000 * |step| + 3 * dt) / (6 * dt)
   assign div_start = (state_ff == S_VDIV);
   assign div_num   = NUM_W'(step_mag_ff) * NUM_W'(1000) + NUM_W'(dt_ff) * NUM_W'(3);
   assign div_den   = DEN_W'(dt_ff) * DEN_W'(6);

   always_comb begin
      mq_x    = mprod_ff[35:3];
      mq_hi   = 50'(mq_x) * 50'(RECIP_STEP[33:17]);
      mq_sum  = 67'(macc_ff) + {mq_hi, 17'd0};
      pq_y    = pos_mag + 32'd500;
      pq_prod = 59'(pq_y[31:3]) * 59'(RECIP_POS);
   end

   always_comb begin
      err_w    = {target_ff[31], target_ff} - {position_ff[31], position_ff};
      err_neg  = err_w[32];
      err_mag  = err_neg ? unsigned'(-err_w) : unsigned'(err_w);
      ms_s     = signed'(step_cap_ff);
      big      = err_mag > step_cap_ff;
      step_w   = big ? (err_neg ? -ms_s : ms_s) : err_w;
      lim34    = signed'({3'b000, cfg.pos_clamp});
      nsum     = {{2{position_ff[31]}}, position_ff} + {step_w[32], step_w};
      if ((cfg.pos_clamp != 31'd0) && (nsum > lim34)) nsum = lim34;
      else if ((cfg.pos_clamp != 31'd0) && (nsum < -lim34)) nsum = -lim34;
      newpos     = nsum[31:0];
      newpos_mag = newpos[31] ? unsigned'(-newpos) : unsigned'(newpos);
      pinned_w   = (cfg.pos_clamp != 31'd0) &&
                   (newpos_mag >= {1'b0, cfg.pos_clamp}) && big;
      pos_mag    = position_ff[31] ? unsigned'(-position_ff) : unsigned'(position_ff);
   end

   always_comb begin
      csum   = {1'b0, cprod_ff} + 58'h0800000;
      cq     = csum[57:24];
      cmag   = (cq > 34'(cfg.effort_limit)) ? cfg.effort_limit : cq[14:0];
      esum33 = {position_ff[31], position_ff} +
               {cfg.encoder_offset[31], cfg.encoder_offset};
      esum   = eacc_ff + 65'd32768;
      eq     = esum[64:16];
      trig   = cfg.mode_bits[MODE_BELOW] ? (position_ff <= cfg.switch_threshold)
                                         : (position_ff >= cfg.switch_threshold);
      pressed = cfg.mode_bits[MODE_ACT_HIGH] ? trig : !trig;
      sw_en   = cfg.mode_bits[MODE_SW_EN];
      enc_en  = cfg.mode_bits[MODE_ENC_EN];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (q_valid && !q_item.is_cmd) state_in = S_MMUL;
         S_MMUL:  state_in = S_MLO;
         S_MLO:   state_in = S_MHI;
         S_MHI:   state_in = S_STEP;
         S_STEP:  state_in = S_VDIV;
         S_VDIV:  state_in = S_VWAIT;
         S_VWAIT: if (div_done) state_in = S_PMUL;
         S_PMUL:  state_in = S_CMUL;
         S_CMUL:  state_in = S_CRND;
         S_CRND:  state_in = S_ELO;
         S_ELO:   state_in = S_EHI;
         S_EHI:   state_in = S_ERND;
         S_ERND:  state_in = S_OSTAT;
         S_OSTAT: if (out_free) state_in = sw_en ? S_OSW : (enc_en ? S_OENC : S_IDLE);
         S_OSW:   if (out_free) state_in = enc_en ? S_OENC : S_IDLE;
         S_OENC:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_free && ((state_ff == S_OSTAT) || (state_ff == S_OSW) ||
                       (state_ff == S_OENC)))
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         position_ff  <= '0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop && q_item.is_cmd && q_item.cmd_ok)
            target_ff <= limit_pos(q_item.target, cfg.pos_clamp);
         if (state_ff == S_STEP) begin
            position_ff <= newpos;
            // re-clamp the target against the current limit
            target_ff   <= limit_pos(target_ff, cfg.pos_clamp);
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE:  dt_ff <= q_item.dt;
         S_MMUL:  mprod_ff <= 36'(cfg.max_speed) * 36'(dt_ff);
         S_MLO:   macc_ff <= 50'(mq_x) * 50'(RECIP_STEP[16:0]);
         S_MHI:   step_cap_ff <= {6'd0, mq_sum[66:40]};
         S_STEP: begin
            err_mag_ff  <= err_mag;
            err_neg_ff  <= err_neg;
            step_mag_ff <= big ? step_cap_ff : err_mag;
            step_neg_ff <= step_w[32];
            pinned_ff   <= pinned_w;
         end
         S_VWAIT: if (div_done) vel_ff <= pinned_ff ? 16'sd0 : sat16(step_neg_ff, div_quot);
         S_PMUL:  pos_ff <= sat16(position_ff[31], NUM_W'(pq_prod[58:36]));
         S_CMUL:  cprod_ff <= 57'(err_mag_ff) * 57'(cfg.current_gain);
         S_CRND: begin
            cur_ff  <= err_neg_ff ? -signed'({1'b0, cmag}) : signed'({1'b0, cmag});
            eneg_ff <= esum33[32] ^ cfg.encoder_scale[31];
            emag_ff <= esum33[32] ? unsigned'(-esum33) : unsigned'(esum33);
            smag_ff <= cfg.encoder_scale[31] ? unsigned'(-cfg.encoder_scale)
                                             : unsigned'(cfg.encoder_scale);
         end
         S_ELO:   eacc_ff <= 65'(emag_ff) * 65'(smag_ff[15:0]);
         S_EHI:   eacc_ff <= eacc_ff + ((65'(emag_ff) * 65'(smag_ff[31:16])) << 16);
         S_ERND: begin
            if (eneg_ff)
               enc_ff <= (eq > 49'h800000) ? 24'sh800000 : -signed'(eq[23:0]);
            else
               enc_ff <= (eq > 49'h7FFFFF) ? 24'sh7FFFFF : signed'(eq[23:0]);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (out_free) begin
         rsp_in = '0;
         case (state_ff)
            S_OSTAT: begin
               rsp_in.frame_kind         = KIND_STATUS;
               rsp_in.position_tenth_deg = pos_ff;
               rsp_in.velocity_tenth_rpm = vel_ff;
               rsp_in.current_centiamp   = cur_ff;
               rsp_in.last               = !sw_en && !enc_en;
            end
            S_OSW: begin
               rsp_in.frame_kind     = KIND_SWITCH;
               rsp_in.switch_pressed = pressed;
               rsp_in.last           = !enc_en;
            end
            S_OENC: begin
               rsp_in.frame_kind  = KIND_ENCODER;
               rsp_in.encoder_raw = enc_ff;
               rsp_in.last        = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

@@ design/emulated_servo_position_integrator.sv @@
// Top level of the servo position integrator: register file, front and back
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    type, elapsed time, frame info, target
//  rsp      out        rsp_valid/stall    kind, status values, switch, encoder, last
//  csr      in         csr_we             index, 32-bit write data
//
// A command takes effect once the back end pops it from the queue; a tick's first
// result waits mostly on the one-bit-per-cycle velocity divider, and each further
// result follows in the next cycle unless rsp_stall holds the output register.
// Up to two items queue ahead of the back end.
// Synchronous reset restores control, target, position and CSRs; no clearing pass.
// A stalled result holds in the output register while the queue keeps filling.
`default_nettype none
module emulated_servo_position_integrator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [15:0]        req_elapsed_us,
   input  logic               req_is_extended,
   input  logic [3:0]         req_frame_length,
   input  logic signed [31:0] req_target_raw,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_frame_kind,
   output logic signed [15:0] rsp_position_tenth_deg,
   output logic signed [15:0] rsp_velocity_tenth_rpm,
   output logic signed [15:0] rsp_current_centiamp,
   output logic               rsp_switch_pressed,
   output logic signed [23:0] rsp_encoder_raw,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import esp_pkg::*;

   cfg_type  cfg_ff;
   logic     q_valid, q_pop;
   item_type q_item;
   rsp_type  rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed        <= 20'd5730;
         cfg_ff.current_gain     <= 24'd11711;
         cfg_ff.effort_limit     <= 15'd600;
         cfg_ff.pos_clamp        <= 31'd0;
         cfg_ff.switch_threshold <= 32'sd0;
         cfg_ff.mode_bits        <= 4'd6;
         cfg_ff.encoder_offset   <= 32'sd0;
         cfg_ff.encoder_scale    <= 32'sd305419;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_SPEED:        cfg_ff.max_speed        <= csr_wdata[19:0];
            CSR_CURRENT_GAIN:     cfg_ff.current_gain     <= csr_wdata[23:0];
            CSR_EFFORT_LIMIT:     cfg_ff.effort_limit     <= csr_wdata[14:0];
            CSR_POS_CLAMP:        cfg_ff.pos_clamp        <= csr_wdata[30:0];
            CSR_SWITCH_THRESHOLD: cfg_ff.switch_threshold <= signed'(csr_wdata);
            CSR_MODE_BITS:        cfg_ff.mode_bits        <= csr_wdata[3:0];
            CSR_ENCODER_OFFSET:   cfg_ff.encoder_offset   <= signed'(csr_wdata);
            CSR_ENCODER_SCALE:    cfg_ff.encoder_scale    <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   esp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_elapsed_us   (req_elapsed_us),
      .req_is_extended  (req_is_extended),
      .req_frame_length (req_frame_length),
      .req_target_raw   (req_target_raw),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   esp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_frame_kind         = rsp.frame_kind;
   assign rsp_position_tenth_deg = rsp.position_tenth_deg;
   assign rsp_velocity_tenth_rpm = rsp.velocity_tenth_rpm;
   assign rsp_current_centiamp   = rsp.current_centiamp;
   assign rsp_switch_pressed     = rsp.switch_pressed;
   assign rsp_encoder_raw        = rsp.encoder_raw;
   assign rsp_last               = rsp.last;

endmodule
`default_nettype wire

@@ design/esp_checker.sv @@
// Port-level checker for the servo position integrator, bound to the top level
`default_nettype none
`include "emulated_servo_position_integrator_macros.svh"
module esp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_frame_kind,
   input  logic signed [15:0] rsp_position_tenth_deg,
   input  logic signed [15:0] rsp_velocity_tenth_rpm,
   input  logic signed [15:0] rsp_current_centiamp,
   input  logic               rsp_switch_pressed,
   input  logic signed [23:0] rsp_encoder_raw,
   input  logic               rsp_last
);
   import esp_pkg::*;

   `ESP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_kind) && $stable(rsp_last) && $stable(rsp_encoder_raw), "stalled result changed")
   `ESP_ASSERT_NOW(a_status_clean, rsp_valid && (rsp_frame_kind == KIND_STATUS), !rsp_switch_pressed && (rsp_encoder_raw == 24'sd0), "status result carries switch or encoder data")
   `ESP_ASSERT_NOW(a_aux_clean, rsp_valid && (rsp_frame_kind != KIND_STATUS), (rsp_position_tenth_deg == 16'sd0) && (rsp_velocity_tenth_rpm == 16'sd0) && (rsp_current_centiamp == 16'sd0), "auxiliary result carries status data")
   `ESP_ASSERT_NOW(a_enc_last, rsp_valid && (rsp_frame_kind == KIND_ENCODER), rsp_last, "encoder result not marked last")

endmodule

bind emulated_servo_position_integrator esp_checker u_esp_checker (.*);
`default_nettype wire
